[design/m4te_pkg.sv]
// Shared constants, types and table functions of the 4x4 transform engine.
`timescale 1ns / 1ps
`default_nettype none
package m4te_pkg;

    localparam int MATRIX_DIM = 4;
    localparam int ELEM_W     = 32;
    localparam int PROD_W     = 64;
    localparam int QPROD_W    = 48;
    localparam int ACC_W      = 50;

    localparam logic signed [31:0] Q_ONE       = 32'sd65536;
    localparam logic signed [32:0] PI_Q        = 33'sd205887;
    localparam logic signed [32:0] HALF_PI_Q   = 33'sd102944;
    localparam logic signed [32:0] TWO_PI_Q    = 33'sd411775;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd39797;
    localparam int CORDIC_STEPS = 16;
    localparam int RED_STEPS    = 14;

    localparam logic [2:0] CMD_IDENT = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_UNIF  = 3'd2;
    localparam logic [2:0] CMD_SCALE = 3'd3;
    localparam logic [2:0] CMD_TRANS = 3'd4;
    localparam logic [2:0] CMD_ROT   = 3'd5;
    localparam logic [2:0] CMD_XFORM = 3'd6;

    typedef struct packed {
        logic               done;
        logic signed [31:0] sin_val;
        logic signed [31:0] cos_val;
    } cordic_res_t;

    function automatic logic signed [31:0] atan_q(input logic [3:0] idx);
        logic signed [31:0] v;
        begin
            case (idx)
                4'd0:    v = 32'sd51472;
                4'd1:    v = 32'sd30386;
                4'd2:    v = 32'sd16055;
                4'd3:    v = 32'sd8150;
                4'd4:    v = 32'sd4091;
                4'd5:    v = 32'sd2047;
                4'd6:    v = 32'sd1024;
                4'd7:    v = 32'sd512;
                4'd8:    v = 32'sd256;
                4'd9:    v = 32'sd128;
                4'd10:   v = 32'sd64;
                4'd11:   v = 32'sd32;
                4'd12:   v = 32'sd16;
                4'd13:   v = 32'sd8;
                4'd14:   v = 32'sd4;
                default: v = 32'sd2;
            endcase
            return v;
        end
    endfunction

    // Element (k, j) of the right-hand matrix of a post-multiply command.
    function automatic logic signed [31:0] r_elem(
        input logic [2:0]        cmd,
        input logic [1:0]        k,
        input logic [1:0]        j,
        input logic [1:0]        ax_a,
        input logic [1:0]        ax_b,
        input logic signed [31:0] ox,
        input logic signed [31:0] oy,
        input logic signed [31:0] oz,
        input logic signed [31:0] cv,
        input logic signed [31:0] sv
    );
        logic signed [31:0] v;
        begin
            v = (k == j) ? Q_ONE : 32'sd0;
            case (cmd)
                CMD_SCALE:
                begin
                    if (k == j)
                    begin
                        case (k)
                            2'd0:    v = ox;
                            2'd1:    v = oy;
                            2'd2:    v = oz;
                            default: v = Q_ONE;
                        endcase
                    end
                end
                CMD_TRANS:
                begin
                    if (j == 2'd3)
                    begin
                        case (k)
                            2'd0:    v = ox;
                            2'd1:    v = oy;
                            2'd2:    v = oz;
                            default: v = Q_ONE;
                        endcase
                    end
                end
                CMD_ROT:
                begin
                    if (k == ax_a && j == ax_a) v = cv;
                    if (k == ax_b && j == ax_b) v = cv;
                    if (k == ax_a && j == ax_b) v = -sv;
                    if (k == ax_b && j == ax_a) v = sv;
                end
                default: v = v;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

[design/m4te_mul.sv]
// Shared Q16.16 multiplier with registered product and truncation toward zero.
`timescale 1ns / 1ps
`default_nettype none
module m4te_mul
    import m4te_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [ELEM_W-1:0]  a,
    input  wire logic signed [ELEM_W-1:0]  b,
    output logic signed [QPROD_W-1:0]      q
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] biased;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign biased = prod_reg + (prod_reg[PROD_W-1] ? 64'sd65535 : 64'sd0);
    assign q      = biased[PROD_W-1:16];

endmodule
`default_nettype wire

[design/m4te_cordic.sv]
// Iterative angle reduction and rotation-mode CORDIC for sine and cosine.
`timescale 1ns / 1ps
`default_nettype none
module m4te_cordic
    import m4te_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] angle,
    output cordic_res_t             res
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_RED  = 3'd1;
    localparam logic [2:0] C_FIX  = 3'd2;
    localparam logic [2:0] C_ROT  = 3'd3;
    localparam logic [2:0] C_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic               sgn_reg, sgn_next;
    logic               neg_reg, neg_next;
    logic signed [32:0] r_reg, r_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic [32:0]        sub_val;
    logic signed [32:0] r0;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        sgn_next   = sgn_reg;
        neg_next   = neg_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sub_val    = 33'(TWO_PI_Q) << cnt_reg;
        r0         = 33'sd0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    sgn_next   = angle[31];
                    rem_next   = angle[31] ? 32'(-angle) : 32'(angle);
                    cnt_next   = 4'(RED_STEPS - 1);
                    state_next = C_RED;
                end
            end
            C_RED:
            begin
                if ({1'b0, rem_reg} >= sub_val)
                begin
                    rem_next = rem_reg - sub_val[31:0];
                end
                if (cnt_reg == 4'd0)
                begin
                    state_next = C_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            C_FIX:
            begin
                if (sgn_reg && rem_reg != 32'd0)
                begin
                    r0 = TWO_PI_Q - $signed({1'b0, rem_reg});
                end
                else
                begin
                    r0 = $signed({1'b0, rem_reg});
                end
                neg_next = 1'b0;
                if (r0 <= HALF_PI_Q)
                begin
                    r_next = r0;
                end
                else if (r0 <= PI_Q)
                begin
                    r_next   = r0 - PI_Q;
                    neg_next = 1'b1;
                end
                else if (r0 < TWO_PI_Q - HALF_PI_Q)
                begin
                    r_next   = r0 - TWO_PI_Q + PI_Q;
                    neg_next = 1'b1;
                end
                else
                begin
                    r_next = r0 - TWO_PI_Q;
                end
                x_next     = CORDIC_GAIN;
                y_next     = 32'sd0;
                cnt_next   = 4'd0;
                state_next = C_ROT;
            end
            C_ROT:
            begin
                if (!r_reg[32])
                begin
                    x_next = x_reg - (y_reg >>> cnt_reg);
                    y_next = y_reg + (x_reg >>> cnt_reg);
                    r_next = r_reg - 33'(atan_q(cnt_reg));
                end
                else
                begin
                    x_next = x_reg + (y_reg >>> cnt_reg);
                    y_next = y_reg - (x_reg >>> cnt_reg);
                    r_next = r_reg + 33'(atan_q(cnt_reg));
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(CORDIC_STEPS - 1))
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        sgn_reg <= sgn_next;
        neg_reg <= neg_next;
        r_reg   <= r_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign res.done    = (state_reg == C_DONE);
    assign res.sin_val = neg_reg ? -y_reg : y_reg;
    assign res.cos_val = neg_reg ? -x_reg : x_reg;

endmodule
`default_nettype wire

[design/matrix4_transform_engine_core.sv]
// Top level of the 4x4 Q16.16 transform matrix engine.
//
// Channel   Direction  Contents
// s_axis    in         tuser: command; tdata: row, col, x, y, z, w
// m_axis    out        tuser: saturated; tdata: result x, y, z, w
//
// Identity, element write and an undefined command complete when accepted; uniform
// multiply, scale, translate, rotate and transform keep the input not ready until done,
// a transform also waiting for the output register. Every product goes through one
// shared multiplier, a multiply and an accumulate step per term, and rotation first
// computes sine and cosine. Reset clears the matrix to zero. A waiting result
// does not block new commands; only the next transform waits for the output register.
`timescale 1ns / 1ps
`default_nettype none
module matrix4_transform_engine_core
    import m4te_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // row, col, x, y, z, w, zero pad
    input  wire logic [2:0]   s_axis_tuser,  // command
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // result x, y, z, w
    output logic              m_axis_tuser   // saturated
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               cmd_reg;
    logic [1:0]               i_reg, j_reg, k_reg;
    logic [1:0]               ax_a_reg, ax_b_reg;
    logic signed [31:0]       ox_reg, oy_reg, oz_reg, ow_reg;
    logic signed [31:0]       cos_reg, sin_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0]       mat_reg [16];
    logic signed [31:0]       row_reg [3];
    logic signed [31:0]       res_reg [4];
    logic                     flag_reg;
    logic                     out_valid_reg;
    logic [127:0]             out_data_reg;
    logic                     out_sat_reg;

    logic                     accept;
    logic signed [31:0]       mul_a, mul_b;
    logic signed [QPROD_W-1:0] q;
    logic signed [ACC_W-1:0]  sum;
    logic signed [31:0]       sat_val;
    logic                     ovf;
    logic                     last_term;
    logic                     out_free;
    cordic_res_t              cres;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    m4te_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && s_axis_tuser == CMD_ROT),
        .angle (s_axis_tdata[131:100]),
        .res   (cres)
    );

    assign mul_a = mat_reg[{i_reg, k_reg}];

    always_comb
    begin
        case (cmd_reg)
            CMD_UNIF:
            begin
                mul_b = ow_reg;
            end
            CMD_XFORM:
            begin
                case (k_reg)
                    2'd0:    mul_b = ox_reg;
                    2'd1:    mul_b = oy_reg;
                    2'd2:    mul_b = oz_reg;
                    default: mul_b = ow_reg;
                endcase
            end
            default:
            begin
                mul_b = r_elem(cmd_reg, k_reg, j_reg, ax_a_reg, ax_b_reg,
                               ox_reg, oy_reg, oz_reg, cos_reg, sin_reg);
            end
        endcase
    end

    m4te_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .q   (q)
    );

    always_comb
    begin
        last_term = (cmd_reg == CMD_UNIF) || (k_reg == 2'd3);
        if (cmd_reg == CMD_UNIF || k_reg == 2'd0)
        begin
            sum = ACC_W'(q);
        end
        else
        begin
            sum = acc_reg + ACC_W'(q);
        end
        ovf = 1'b1;
        if (sum > ACC_W'(32'sh7FFFFFFF))
        begin
            sat_val = 32'sh7FFFFFFF;
        end
        else if (sum < -ACC_W'(64'sh80000000))
        begin
            sat_val = 32'sh80000000;
        end
        else
        begin
            sat_val = sum[31:0];
            ovf     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= 2'd0;
            j_reg         <= 2'd0;
            k_reg         <= 2'd0;
            for (int n = 0; n < 16; n++)
            begin
                mat_reg[n] <= 32'sd0;
            end
        end
        else
        begin
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        i_reg <= 2'd0;
                        j_reg <= 2'd0;
                        k_reg <= 2'd0;
                        case (s_axis_tuser) inside
                            CMD_IDENT:
                            begin
                                for (int n = 0; n < 16; n++)
                                begin
                                    mat_reg[n] <= (n % 5 == 0) ? Q_ONE : 32'sd0;
                                end
                            end
                            CMD_WRITE:
                            begin
                                mat_reg[{s_axis_tdata[1:0], s_axis_tdata[3:2]}]
                                    <= s_axis_tdata[131:100];
                            end
                            CMD_UNIF, CMD_SCALE, CMD_TRANS, CMD_XFORM:
                            begin
                                state_reg <= S_MUL;
                            end
                            CMD_ROT:
                            begin
                                state_reg <= S_CORD;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CORD:
                begin
                    if (cres.done)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (!last_term)
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                    else if (cmd_reg == CMD_UNIF)
                    begin
                        mat_reg[{i_reg, k_reg}] <= sat_val;
                        {i_reg, k_reg} <= {i_reg, k_reg} + 4'd1;
                        state_reg <= ({i_reg, k_reg} == 4'hF) ? S_IDLE : S_MUL;
                    end
                    else if (cmd_reg == CMD_XFORM)
                    begin
                        k_reg     <= 2'd0;
                        i_reg     <= i_reg + 2'd1;
                        state_reg <= (i_reg == 2'd3) ? S_EMIT : S_MUL;
                    end
                    else
                    begin
                        k_reg     <= 2'd0;
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= (j_reg == 2'd3 && i_reg == 2'd3) ? S_IDLE : S_MUL;
                        if (j_reg == 2'd3)
                        begin
                            mat_reg[{i_reg, 2'd0}] <= row_reg[0];
                            mat_reg[{i_reg, 2'd1}] <= row_reg[1];
                            mat_reg[{i_reg, 2'd2}] <= row_reg[2];
                            mat_reg[{i_reg, 2'd3}] <= sat_val;
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_axis_tuser;
            ox_reg   <= s_axis_tdata[35:4];
            oy_reg   <= s_axis_tdata[67:36];
            oz_reg   <= s_axis_tdata[99:68];
            ow_reg   <= s_axis_tdata[131:100];
            flag_reg <= 1'b0;
            if (!s_axis_tdata[35] && s_axis_tdata[35:4] != 32'd0)
            begin
                ax_a_reg <= 2'd1;
                ax_b_reg <= 2'd2;
            end
            else if (!s_axis_tdata[67] && s_axis_tdata[67:36] != 32'd0)
            begin
                ax_a_reg <= 2'd2;
                ax_b_reg <= 2'd0;
            end
            else
            begin
                ax_a_reg <= 2'd1;
                ax_b_reg <= 2'd0;
            end
        end
        if (state_reg == S_CORD && cres.done)
        begin
            cos_reg <= cres.cos_val;
            sin_reg <= cres.sin_val;
        end
        if (state_reg == S_ACC)
        begin
            acc_reg <= sum;
            if (last_term && cmd_reg == CMD_XFORM)
            begin
                res_reg[i_reg] <= sat_val;
                flag_reg       <= flag_reg | ovf;
            end
            if (last_term && j_reg != 2'd3)
            begin
                row_reg[j_reg] <= sat_val;
            end
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_data_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
            out_sat_reg  <= flag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> out_valid_reg)
        else $error("result not presented after emit");
    a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cres.done |-> state_reg == S_CORD)
        else $error("sine and cosine finished while not waiting");
`endif

endmodule
`default_nettype wire

[tb/matrix4_transform_engine_core_test.sv]
// Self-checking testbench of the 4x4 Q16.16 transform matrix engine.
`timescale 1ns / 1ps
module matrix4_transform_engine_core_test;
    import m4te_pkg::*;

    typedef struct {
        logic [2:0]         cmd;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
    } cmd_item_t;

    typedef struct {
        logic [127:0] vec;
        logic         sat;
    } vec_result_t;

    class xform_scoreboard;
        logic signed [31:0] mtx[16];
        vec_result_t        expected_vecs[$];
        int                 errors;

        function new();
            foreach (mtx[i]) mtx[i] = 0;
            errors = 0;
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b) / 65536;
        endfunction

        function logic signed [31:0] clamp(longint v, inout bit flag);
            if (v > 64'sd2147483647)
            begin
                flag = 1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648)
            begin
                flag = 1;
                return 32'sh80000000;
            end
            return v[31:0];
        endfunction

        function void sin_cos(longint ang, output longint s, output longint c);
            longint r;
            longint x;
            longint y;
            longint dx;
            longint dy;
            longint atan_v[16];
            bit flip;
            atan_v = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2};
            r = ang % 411775;
            flip = 0;
            x = 39797;
            y = 0;
            if (r < 0) r += 411775;
            if (r > 205887) r -= 411775;
            if (r > 102944)
            begin
                r -= 205887;
                flip = 1;
            end
            else if (r < -102944)
            begin
                r += 205887;
                flip = 1;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (r >= 0)
                begin
                    x -= dx;
                    y += dy;
                    r -= atan_v[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    r += atan_v[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            s = y;
            c = x;
        endfunction

        function void post_multiply(longint rm[16]);
            logic signed [31:0] res[16];
            longint acc;
            bit ignored;
            ignored = 0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += qmul(mtx[i * 4 + k], rm[k * 4 + j]);
                    res[i * 4 + j] = clamp(acc, ignored);
                end
            mtx = res;
        endfunction

        function void note_input(cmd_item_t it);
            longint rm[16];
            longint vin[4];
            longint acc;
            longint s;
            longint c;
            int a;
            int b;
            bit flag;
            vec_result_t e;
            flag = 0;
            foreach (rm[i]) rm[i] = (i % 5 == 0) ? 65536 : 0;
            case (it.cmd)
                CMD_IDENT:
                    foreach (mtx[i]) mtx[i] = rm[i];
                CMD_WRITE:
                    mtx[it.row * 4 + it.col] = it.w;
                CMD_UNIF:
                    foreach (mtx[i]) mtx[i] = clamp(qmul(mtx[i], it.w), flag);
                CMD_SCALE:
                begin
                    rm[0] = it.x;
                    rm[5] = it.y;
                    rm[10] = it.z;
                    post_multiply(rm);
                end
                CMD_TRANS:
                begin
                    rm[3] = it.x;
                    rm[7] = it.y;
                    rm[11] = it.z;
                    post_multiply(rm);
                end
                CMD_ROT:
                begin
                    sin_cos(it.w, s, c);
                    if (it.x > 0)
                    begin
                        a = 1;
                        b = 2;
                    end
                    else if (it.y > 0)
                    begin
                        a = 2;
                        b = 0;
                    end
                    else
                    begin
                        a = 1;
                        b = 0;
                    end
                    rm[a * 4 + a] = c;
                    rm[b * 4 + b] = c;
                    rm[a * 4 + b] = -s;
                    rm[b * 4 + a] = s;
                    post_multiply(rm);
                end
                CMD_XFORM:
                begin
                    vin = '{it.x, it.y, it.z, it.w};
                    for (int i = 0; i < 4; i++)
                    begin
                        acc = 0;
                        for (int j = 0; j < 4; j++)
                            acc += qmul(mtx[i * 4 + j], vin[j]);
                        e.vec[i * 32 +: 32] = clamp(acc, flag);
                    end
                    e.sat = flag;
                    expected_vecs.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [127:0] vec, logic sat);
            vec_result_t e;
            string names[4];
            names = '{"result_x", "result_y", "result_z", "result_w"};
            if (expected_vecs.size() == 0)
            begin
                $error("Unexpected result transaction %h", vec);
                errors++;
                return;
            end
            e = expected_vecs.pop_front();
            for (int i = 0; i < 4; i++)
                if (vec[i * 32 +: 32] !== e.vec[i * 32 +: 32])
                begin
                    $error("%s: expected %h, actual %h", names[i],
                           e.vec[i * 32 +: 32], vec[i * 32 +: 32]);
                    errors++;
                end
            if (sat !== e.sat)
            begin
                $error("saturated: expected %b, actual %b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;

    xform_scoreboard sb;
    int idle_cycles;
    int burst_left;
    int stall_mode;
    int stall_count;

    matrix4_transform_engine_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input('{s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[3:2],
                            s_axis_tdata[35:4], s_axis_tdata[67:36],
                            s_axis_tdata[99:68], s_axis_tdata[131:100]});
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // The receiver switches between always ready, sparse stalls and long stalls.
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_count <= $urandom_range(20, 300);
        end
        else
            stall_count <= stall_count - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1, 2:    return 32'sd65536 + $signed($urandom_range(0, 16384)) - 8192;
            3:       return -32'sd65536 + $signed($urandom_range(0, 16384)) - 8192;
            default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        endcase
    endfunction

    task automatic send(cmd_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 20) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {4'b0, it.w, it.z, it.y, it.x, it.col, it.row};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_cmd(logic [2:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [31:0] w);
        send('{cmd, $urandom_range(0, 3), $urandom_range(0, 3), x, y, z, w});
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_vecs.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        cmd_item_t it;
        int pick;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero matrix, extremes, every axis and angle range, undefined command.
        send_cmd(CMD_XFORM, 32'sh7fffffff, 32'sh80000000, 1, -1);
        send_cmd(CMD_IDENT, 0, 0, 0, 0);
        send_cmd(CMD_XFORM, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send('{CMD_WRITE, 2'd3, 2'd3, -1, -1, -1, 32'sh7fffffff});
        send('{CMD_WRITE, 2'd0, 2'd3, 0, 0, 0, 32'sh80000000});
        send_cmd(CMD_XFORM, 32'sh7fffffff, 0, 0, 32'sh7fffffff);
        send_cmd(3'd7, -1, -1, -1, -1);
        send_cmd(CMD_UNIF, 0, 0, 0, 32'sh7fffffff);
        send_cmd(CMD_XFORM, 65536, 65536, 65536, 65536);
        send_cmd(CMD_IDENT, 0, 0, 0, 0);
        send_cmd(CMD_SCALE, 32'sh7fffffff, 32'sh80000000, 131072, 0);
        send_cmd(CMD_TRANS, 32'sh80000000, 32'sh7fffffff, -65536, 0);
        send_cmd(CMD_XFORM, 65536, 65536, 65536, 65536);
        send_cmd(CMD_IDENT, 0, 0, 0, 0);
        send_cmd(CMD_ROT, 65536, 0, 0, 32'sh7fffffff);
        send_cmd(CMD_ROT, 0, 65536, 0, 32'sh80000000);
        send_cmd(CMD_ROT, -1, 0, 0, 205887);
        send_cmd(CMD_ROT, 0, -1, 0, -205887);
        send_cmd(CMD_ROT, 1, 1, 0, 102944);
        send_cmd(CMD_ROT, 0, 1, 0, -102945);
        send_cmd(CMD_ROT, 0, 0, 0, 411775);
        send_cmd(CMD_XFORM, 65536, -65536, 32768, 65536);
        drain();

        for (int n = 0; n < 1350; n++)
        begin
            pick = $urandom_range(0, 99);
            it.row = $urandom_range(0, 3);
            it.col = $urandom_range(0, 3);
            it.x = rand_q();
            it.y = rand_q();
            it.z = rand_q();
            it.w = rand_q();
            if (pick < 5) it.cmd = CMD_IDENT;
            else if (pick < 15) it.cmd = CMD_WRITE;
            else if (pick < 22) it.cmd = CMD_UNIF;
            else if (pick < 33) it.cmd = CMD_SCALE;
            else if (pick < 44) it.cmd = CMD_TRANS;
            else if (pick < 60)
            begin
                it.cmd = CMD_ROT;
                if ($urandom_range(0, 1)) it.w = $urandom;
            end
            else if (pick < 97) it.cmd = CMD_XFORM;
            else it.cmd = 3'd7;
            send(it);
            if (n % 400 == 399) drain();
        end

        drain();
        if (sb.errors == 0 && sb.expected_vecs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
